// ===== rtl/core/mms_pkg.sv =====
`timescale 1ns / 1ps

package mms_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } t_status;

    // shift control broadcast along a chain of cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam logic ADDR_TRACK_MIN = 1'b0;

endpackage

// ===== rtl/core/mms_cell.sv =====
`timescale 1ns / 1ps

module mms_cell #(
    parameter int WIDTH = 32
) (
    input  logic                    i_clk,
    input  mms_pkg::t_shift         i_shift,
    input  logic signed [WIDTH-1:0] i_upper,
    input  logic signed [WIDTH-1:0] i_lower,
    output logic signed [WIDTH-1:0] o_entry
);
    import mms_pkg::*;

    logic signed [WIDTH-1:0] r_entry;
    logic signed [WIDTH-1:0] n_entry;

    always_comb begin
        priority if (i_shift.push) begin
            n_entry = i_upper;
        end else if (i_shift.pop) begin
            n_entry = i_lower;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/min_max_tracking_stack_top.sv =====
`timescale 1ns / 1ps

// Bounded LIFO of signed words that also reports its running maximum
// (track_min = 0) or minimum (track_min = 1). Both the data stack and the
// record stack are chains of DEPTH shift cells with the top held in the first
// cell. A transaction is accepted every clock while the output register is
// free or being drained, and its result appears in the output register in
// the cycle after acceptance. Underflow (pop or query on empty) and overflow
// (push on full) are flagged in status and leave the state untouched; command
// 3 behaves as a query. There is no clearing pass after reset; only the two
// occupancy counters, the output valid flag and track_min are reset.
module min_max_tracking_stack_top #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic signed [WIDTH-1:0]            i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [WIDTH-1:0]            o_data,
    output logic signed [WIDTH-1:0]            o_extreme,
    output logic                               o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0]         o_occupancy,
    output logic [1:0]                         o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mms_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mms_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mms_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import mms_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic                    r_track_min;
    logic [CW-1:0]           r_main_cnt, n_main_cnt;
    logic [CW-1:0]           r_ext_cnt, n_ext_cnt;
    logic                    r_valid;
    logic signed [WIDTH-1:0] r_data, n_data;
    logic signed [WIDTH-1:0] r_extreme, n_extreme;
    logic [1:0]              r_status;
    t_status                 n_status;

    logic signed [WIDTH-1:0] w_main [DEPTH];
    logic signed [WIDTH-1:0] w_ext  [DEPTH];
    t_shift                  w_main_sh, w_ext_sh;
    logic                    w_accept, w_take, w_ext_pop;

    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == ADDR_TRACK_MIN)
                    ? {{(APB_DATA_W-1){1'b0}}, r_track_min} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_min <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_ADDR_W-1] == ADDR_TRACK_MIN) begin
            r_track_min <= pwdata[0];
        end
    end

    assign w_take = (r_ext_cnt == '0)
                    || (r_track_min ? (i_value <= w_ext[0]) : (i_value >= w_ext[0]));
    assign w_ext_pop = (r_ext_cnt != '0) && (w_ext[0] == w_main[0]);

    always_comb begin
        w_main_sh  = '0;
        w_ext_sh   = '0;
        n_main_cnt = r_main_cnt;
        n_ext_cnt  = r_ext_cnt;
        n_data     = '0;
        n_status   = STATUS_OK;
        n_extreme  = (r_ext_cnt != '0) ? w_ext[0] : '0;
        unique case (t_cmd'(i_cmd))
            CMD_PUSH: begin
                if (r_main_cnt >= FULL) begin
                    n_status = STATUS_OVERFLOW;
                end else begin
                    w_main_sh.push = w_accept;
                    n_main_cnt     = r_main_cnt + ONE;
                    if (w_take && r_ext_cnt < FULL) begin
                        w_ext_sh.push = w_accept;
                        n_ext_cnt     = r_ext_cnt + ONE;
                        n_extreme     = i_value;
                    end
                end
            end
            CMD_POP: begin
                if (r_main_cnt == '0) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    w_main_sh.pop = w_accept;
                    n_main_cnt    = r_main_cnt - ONE;
                    n_data        = w_main[0];
                    if (w_ext_pop) begin
                        w_ext_sh.pop = w_accept;
                        n_ext_cnt    = r_ext_cnt - ONE;
                        n_extreme    = (r_ext_cnt > ONE) ? w_ext[1] : '0;
                    end
                end
            end
            default: begin
                if (r_main_cnt == '0) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    n_data = w_main[0];
                end
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [WIDTH-1:0] w_main_up, w_main_dn, w_ext_up, w_ext_dn;
            if (gi == 0) begin : g_first
                assign w_main_up = i_value;
                assign w_ext_up  = i_value;
            end else begin : g_mid
                assign w_main_up = w_main[gi-1];
                assign w_ext_up  = w_ext[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_main_dn = w_main[gi];
                assign w_ext_dn  = w_ext[gi];
            end else begin : g_inner
                assign w_main_dn = w_main[gi+1];
                assign w_ext_dn  = w_ext[gi+1];
            end
            mms_cell #(.WIDTH(WIDTH)) u_main (
                .i_clk   (i_clk),
                .i_shift (w_main_sh),
                .i_upper (w_main_up),
                .i_lower (w_main_dn),
                .o_entry (w_main[gi])
            );
            mms_cell #(.WIDTH(WIDTH)) u_ext (
                .i_clk   (i_clk),
                .i_shift (w_ext_sh),
                .i_upper (w_ext_up),
                .i_lower (w_ext_dn),
                .o_entry (w_ext[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_cnt <= '0;
            r_ext_cnt  <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_main_cnt <= n_main_cnt;
                r_ext_cnt  <= n_ext_cnt;
                r_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data    <= n_data;
            r_extreme <= n_extreme;
            r_status  <= n_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_extreme   = r_extreme;
    assign o_occupancy = r_main_cnt;
    assign o_is_empty  = (r_main_cnt == '0);
    assign o_status    = r_status;

endmodule

// ===== rtl/core/mms_checker.sv =====
`timescale 1ns / 1ps

module mms_checker #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [WIDTH-1:0]    o_data,
    input logic signed [WIDTH-1:0]    o_extreme,
    input logic                       o_is_empty,
    input logic [$clog2(DEPTH+1)-1:0] o_occupancy,
    input logic [1:0]                 o_status
);
    import mms_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result transaction dropped while stalled");

    a_empty_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_OVERFLOW |-> o_occupancy == CW'(DEPTH) && o_data == '0)
        else $error("overflow reported while not full");

    a_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_UNDERFLOW |-> o_is_empty && o_data == '0
            && o_extreme == '0)
        else $error("underflow reported with entries present");

endmodule

bind min_max_tracking_stack_top mms_checker #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
) u_mms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data      (o_data),
    .o_extreme   (o_extreme),
    .o_is_empty  (o_is_empty),
    .o_occupancy (o_occupancy),
    .o_status    (o_status)
);
